// ===== rtl/midi_encoder_step_decoder_unit_assert.svh =====
// Assertion macros for the MIDI encoder step decoder.
// Included by files that check their own logic; no other dependencies.
`ifndef MIDI_ENCODER_STEP_DECODER_UNIT_ASSERT_SVH
`define MIDI_ENCODER_STEP_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MESD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mesd assertion failed");
`define MESD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mesd assertion failed");
`else
`define MESD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define MESD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/mesd_pkg.sv =====
// Shared types, codes and constants of the MIDI encoder step decoder.
// No dependencies.
`default_nettype none

package mesd_pkg;

	localparam int unsigned KNOB_W   = 7;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned DLY_W    = 9;
	localparam int unsigned SKIP_W   = 8;
	localparam int unsigned MODE_W   = 4;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DAT_W = 32;

	localparam logic [KNOB_W-1:0] KNOB_CENTER          = 7'd64;
	localparam logic [KNOB_W-1:0] KNOB_FAST_DOWN_BELOW = 7'd61;
	localparam logic [KNOB_W-1:0] KNOB_FAST_UP_ABOVE   = 7'd68;
	localparam logic [KNOB_W-1:0] KNOB_MIN             = 7'd0;
	localparam logic [KNOB_W-1:0] KNOB_MAX             = 7'd127;

	// mode_bits positions
	localparam int unsigned MODE_RANGE  = 0;
	localparam int unsigned MODE_VALUE  = 1;
	localparam int unsigned MODE_MIN_EN = 2;
	localparam int unsigned MODE_MAX_EN = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE       = 4'd0,
		REG_DELAY      = 4'd1,
		REG_STEP_UP    = 4'd2,
		REG_STEP_DOWN  = 4'd3,
		REG_STEP_FUP   = 4'd4,
		REG_STEP_FDOWN = 4'd5,
		REG_LIMIT_MIN  = 4'd6,
		REG_LIMIT_MAX  = 4'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_PROCESSED    = 2'd0,
		ST_LAYER_SKIP   = 2'd1,
		ST_PRESCALE_SKIP = 2'd2,
		ST_PRIMED       = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_UP        = 3'd1,
		ACT_DOWN      = 3'd2,
		ACT_FAST_UP   = 3'd3,
		ACT_FAST_DOWN = 3'd4
	} action_t;

	typedef struct packed {
		logic [MODE_W-1:0]       mode_bits;
		logic signed [DLY_W-1:0] delay_count;
		logic signed [VAL_W-1:0] step_up;
		logic signed [VAL_W-1:0] step_down;
		logic signed [VAL_W-1:0] step_fast_up;
		logic signed [VAL_W-1:0] step_fast_down;
		logic signed [VAL_W-1:0] limit_min;
		logic signed [VAL_W-1:0] limit_max;
	} cfg_t;

	typedef struct packed {
		logic                    layer_active;
		logic [KNOB_W-1:0]       knob_value;
		logic signed [VAL_W-1:0] current_value;
	} in_item_t;

	typedef struct packed {
		status_t                 status;
		action_t                 action;
		logic                    value_write;
		logic signed [VAL_W-1:0] new_value;
	} out_item_t;

	typedef struct packed {
		logic [KNOB_W-1:0] prev_knob;
		logic              prev_known;
		logic [SKIP_W-1:0] skip_count;
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/mesd_if.sv =====
// Handshake channel interfaces: encoder items in, decoded items out, config writes.
// Depends on mesd_pkg for field widths.
`default_nettype none

interface mesd_in_if;
	logic                              valid;
	logic                              ready;
	logic                              layer_active;
	logic [mesd_pkg::KNOB_W-1:0]       knob_value;
	logic signed [mesd_pkg::VAL_W-1:0] current_value;
	modport source (output valid, output layer_active, output knob_value,
		output current_value, input ready);
	modport sink (input valid, input layer_active, input knob_value,
		input current_value, output ready);
endinterface

interface mesd_out_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        status;
	logic [2:0]                        action;
	logic                              value_write;
	logic signed [mesd_pkg::VAL_W-1:0] new_value;
	modport source (output valid, output status, output action, output value_write,
		output new_value, input ready);
	modport sink (input valid, input status, input action, input value_write,
		input new_value, output ready);
endinterface

interface mesd_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [mesd_pkg::CFG_IDX_W-1:0]     index;
	logic [mesd_pkg::CFG_DAT_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/midi_encoder_step_decoder_unit.sv =====
// Top level of the MIDI encoder step decoder: input register, decode, result register.
// Depends on mesd_pkg, mesd_if, mesd_cfg_regs, mesd_step and the assertion header.
`default_nettype none

`include "midi_encoder_step_decoder_unit_assert.svh"

// Decodes one relative or absolute encoder message per item into a status, an
// action code and, in value mode, a stepped and clamped Q16.16 value. Every item
// gives exactly one result. From acceptance it passes through the input register,
// then the result register, to result valid; one item is accepted per cycle
// as long as the result side keeps taking results, the single decode/add/clamp
// stage between the two registers setting that rate. Configuration writes are
// taken every cycle and must only be issued while no items are in flight.
module midi_encoder_step_decoder_unit (
	input  wire         clk,
	input  wire         arst_n,
	mesd_cfg_if.sink    cfg,
	mesd_in_if.sink     knob,
	mesd_out_if.source  result
);
	import mesd_pkg::*;

	cfg_t      regs;
	state_t    state_q;
	state_t    state_next;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_c;
	out_item_t res_s2;
	logic      valid_s2;
	logic      s2_free;
	logic      s1_adv;

	mesd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	mesd_step u_step (
		.regs       (regs),
		.state      (state_q),
		.item       (item_s1),
		.res        (res_c),
		.state_next (state_next)
	);

	assign s2_free    = !valid_s2 || result.ready;
	assign s1_adv     = valid_s1 && s2_free;
	assign knob.ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (knob.ready)
				valid_s1 <= knob.valid;
			if (s2_free)
				valid_s2 <= valid_s1;
			if (s1_adv)
				state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (knob.valid && knob.ready) begin
			item_s1.layer_active  <= knob.layer_active;
			item_s1.knob_value    <= knob.knob_value;
			item_s1.current_value <= knob.current_value;
		end
		if (s1_adv)
			res_s2 <= res_c;
	end

	assign result.valid       = valid_s2;
	assign result.status      = res_s2.status;
	assign result.action      = res_s2.action;
	assign result.value_write = res_s2.value_write;
	assign result.new_value   = res_s2.new_value;

	`MESD_ASSERT_NOW(a_skip_no_write, clk, arst_n, valid_s2 && res_s2.status != ST_PROCESSED, !res_s2.value_write && res_s2.action == ACT_NONE)
	`MESD_ASSERT_NOW(a_cmd_no_write, clk, arst_n, valid_s2 && !regs.mode_bits[MODE_VALUE], !res_s2.value_write)
	`MESD_ASSERT_NXT(a_primed_known, clk, arst_n, s1_adv && res_c.status == ST_PRIMED, state_q.prev_known)
	`MESD_ASSERT_NOW(a_stall_holds_s1, clk, arst_n, valid_s2 && !result.ready, !s1_adv)

endmodule

`default_nettype wire

// ===== rtl/mesd_cfg_regs.sv =====
// Configuration register file of the MIDI encoder step decoder.
// Depends on mesd_pkg and mesd_if.
`default_nettype none

module mesd_cfg_regs (
	input  wire            clk,
	input  wire            arst_n,
	mesd_cfg_if.sink       cfg,
	output mesd_pkg::cfg_t regs
);
	import mesd_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.mode_bits      <= '0;
			regs_q.delay_count    <= '1;
			regs_q.step_up        <= '0;
			regs_q.step_down      <= '0;
			regs_q.step_fast_up   <= '0;
			regs_q.step_fast_down <= '0;
			regs_q.limit_min      <= '0;
			regs_q.limit_max      <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MODE:       regs_q.mode_bits      <= cfg.data[MODE_W-1:0];
				REG_DELAY:      regs_q.delay_count    <= cfg.data[DLY_W-1:0];
				REG_STEP_UP:    regs_q.step_up        <= cfg.data[VAL_W-1:0];
				REG_STEP_DOWN:  regs_q.step_down      <= cfg.data[VAL_W-1:0];
				REG_STEP_FUP:   regs_q.step_fast_up   <= cfg.data[VAL_W-1:0];
				REG_STEP_FDOWN: regs_q.step_fast_down <= cfg.data[VAL_W-1:0];
				REG_LIMIT_MIN:  regs_q.limit_min      <= cfg.data[VAL_W-1:0];
				REG_LIMIT_MAX:  regs_q.limit_max      <= cfg.data[VAL_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mesd_step.sv =====
// Decode of one encoder item: layer filter, prescaler, direction, step, clamp.
// Pure combinational; depends on mesd_pkg.
`default_nettype none

module mesd_step (
	input  wire mesd_pkg::cfg_t      regs,
	input  wire mesd_pkg::state_t    state,
	input  wire mesd_pkg::in_item_t  item,
	output mesd_pkg::out_item_t res,
	output mesd_pkg::state_t    state_next
);
	import mesd_pkg::*;

	logic                    range_mode;
	logic                    value_mode;
	logic                    presc_skip;
	logic                    primed;
	action_t                 act;
	logic signed [VAL_W-1:0] step;
	logic signed [VAL_W:0]   sum;
	logic signed [VAL_W:0]   clamped;
	logic signed [VAL_W-1:0] sat;

	assign range_mode = regs.mode_bits[MODE_RANGE];
	assign value_mode = regs.mode_bits[MODE_VALUE];
	assign presc_skip = !regs.delay_count[DLY_W-1] &&
		(state.skip_count < regs.delay_count[SKIP_W-1:0]);
	assign primed     = value_mode && range_mode && !state.prev_known;

	always_comb begin
		act = ACT_NONE;
		if (!range_mode) begin
			if (item.knob_value < KNOB_CENTER)
				act = (item.knob_value < KNOB_FAST_DOWN_BELOW) ? ACT_FAST_DOWN : ACT_DOWN;
			else if (item.knob_value > KNOB_CENTER)
				act = (item.knob_value > KNOB_FAST_UP_ABOVE) ? ACT_FAST_UP : ACT_UP;
		end else if (item.knob_value == KNOB_MIN) begin
			act = ACT_DOWN;
		end else if (item.knob_value == KNOB_MAX) begin
			act = ACT_UP;
		end else if (!state.prev_known || item.knob_value > state.prev_knob) begin
			// unknown previous counts as -1
			act = ACT_UP;
		end else begin
			act = ACT_DOWN;
		end
	end

	always_comb begin
		case (act)
			ACT_UP:        step = regs.step_up;
			ACT_DOWN:      step = regs.step_down;
			ACT_FAST_UP:   step = regs.step_fast_up;
			ACT_FAST_DOWN: step = regs.step_fast_down;
			default:       step = '0;
		endcase
		sum     = {item.current_value[VAL_W-1], item.current_value} + {step[VAL_W-1], step};
		clamped = sum;
		if (step[VAL_W-1]) begin
			if (regs.mode_bits[MODE_MIN_EN] &&
					sum < $signed({regs.limit_min[VAL_W-1], regs.limit_min}))
				clamped = {regs.limit_min[VAL_W-1], regs.limit_min};
		end else begin
			if (regs.mode_bits[MODE_MAX_EN] &&
					sum > $signed({regs.limit_max[VAL_W-1], regs.limit_max}))
				clamped = {regs.limit_max[VAL_W-1], regs.limit_max};
		end
		if (clamped[VAL_W] != clamped[VAL_W-1])
			sat = clamped[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		else
			sat = clamped[VAL_W-1:0];
	end

	always_comb begin
		res        = '0;
		state_next = state;
		if (!item.layer_active) begin
			res.status = ST_LAYER_SKIP;
		end else if (presc_skip) begin
			res.status            = ST_PRESCALE_SKIP;
			state_next.skip_count = state.skip_count + SKIP_W'(1);
		end else begin
			if (!regs.delay_count[DLY_W-1])
				state_next.skip_count = '0;
			if (primed) begin
				res.status = ST_PRIMED;
			end else begin
				res.status = ST_PROCESSED;
				res.action = act;
				if (value_mode) begin
					res.value_write = 1'b1;
					res.new_value   = sat;
				end
			end
			if (value_mode || range_mode) begin
				state_next.prev_knob  = item.knob_value;
				state_next.prev_known = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for midi_encoder_step_decoder_unit: directed and random encoder items,
// each result checked against an in-bench decoder model. Needs mesd_pkg, mesd_if, RTL.
module tb;
	import mesd_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 6;
	localparam int RAND_PHASES    = 7;
	localparam int PHASE_ITEMS    = 130;

	localparam logic [3:0] M_RANGE = 4'(1 << MODE_RANGE);
	localparam logic [3:0] M_VALUE = 4'(1 << MODE_VALUE);
	localparam logic [3:0] M_MIN   = 4'(1 << MODE_MIN_EN);
	localparam logic [3:0] M_MAX   = 4'(1 << MODE_MAX_EN);

	localparam logic [31:0] Q_ONE  = 32'h0001_0000;
	localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN  = 32'h8000_0000;
	localparam longint      SUM_HI = 64'sd2147483647;
	localparam longint      SUM_LO = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n;

	always #5 clk = ~clk;

	mesd_cfg_if cfg ();
	mesd_in_if  knob ();
	mesd_out_if result ();

	midi_encoder_step_decoder_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.knob   (knob),
		.result (result)
	);

	// decoder model state
	cfg_t       dec_cfg;
	logic [6:0] last_knob;
	logic       last_known;
	logic [7:0] skip_cnt;

	out_item_t  pending[$];
	int         mismatches;
	int         n_sent;
	int         n_checked;
	int         idle_pct = 18;
	bit         hold_req;
	int         quiet_cycles;

	function automatic void apply_reg(reg_idx_t idx, logic [31:0] d);
		case (idx)
			REG_MODE:       dec_cfg.mode_bits      = d[MODE_W-1:0];
			REG_DELAY:      dec_cfg.delay_count    = d[DLY_W-1:0];
			REG_STEP_UP:    dec_cfg.step_up        = d;
			REG_STEP_DOWN:  dec_cfg.step_down      = d;
			REG_STEP_FUP:   dec_cfg.step_fast_up   = d;
			REG_STEP_FDOWN: dec_cfg.step_fast_down = d;
			REG_LIMIT_MIN:  dec_cfg.limit_min      = d;
			REG_LIMIT_MAX:  dec_cfg.limit_max      = d;
			default: ;
		endcase
	endfunction

	function automatic out_item_t decode_knob(logic la, logic [6:0] kv, logic [31:0] cur);
		out_item_t r;
		logic      range_m;
		logic      value_m;
		action_t   act;
		longint    stp;
		longint    sum;
		longint    lim;
		r = '0;
		range_m = dec_cfg.mode_bits[MODE_RANGE];
		value_m = dec_cfg.mode_bits[MODE_VALUE];
		act = ACT_NONE;
		if (!la) begin
			r.status = ST_LAYER_SKIP;
			return r;
		end
		if (!dec_cfg.delay_count[DLY_W-1]) begin
			if ({1'b0, skip_cnt} < dec_cfg.delay_count) begin
				skip_cnt = skip_cnt + 8'd1;
				r.status = ST_PRESCALE_SKIP;
				return r;
			end
			skip_cnt = '0;
		end
		if (value_m && range_m && !last_known) begin
			last_knob = kv;
			last_known = 1'b1;
			r.status = ST_PRIMED;
			return r;
		end
		if (!range_m) begin
			if (kv < KNOB_CENTER)
				act = (kv < KNOB_FAST_DOWN_BELOW) ? ACT_FAST_DOWN : ACT_DOWN;
			else if (kv > KNOB_CENTER)
				act = (kv > KNOB_FAST_UP_ABOVE) ? ACT_FAST_UP : ACT_UP;
		end else if (kv == KNOB_MIN) begin
			act = ACT_DOWN;
		end else if (kv == KNOB_MAX) begin
			act = ACT_UP;
		end else if (!last_known || kv > last_knob) begin
			// unknown previous counts as -1
			act = ACT_UP;
		end else begin
			act = ACT_DOWN;
		end
		if (value_m || range_m) begin
			last_knob = kv;
			last_known = 1'b1;
		end
		r.action = act;
		if (value_m) begin
			case (act)
				ACT_UP:        stp = longint'($signed(dec_cfg.step_up));
				ACT_DOWN:      stp = longint'($signed(dec_cfg.step_down));
				ACT_FAST_UP:   stp = longint'($signed(dec_cfg.step_fast_up));
				ACT_FAST_DOWN: stp = longint'($signed(dec_cfg.step_fast_down));
				default:       stp = 0;
			endcase
			sum = longint'($signed(cur)) + stp;
			if (stp < 0) begin
				lim = longint'($signed(dec_cfg.limit_min));
				if (dec_cfg.mode_bits[MODE_MIN_EN] && sum < lim)
					sum = lim;
			end else begin
				lim = longint'($signed(dec_cfg.limit_max));
				if (dec_cfg.mode_bits[MODE_MAX_EN] && sum > lim)
					sum = lim;
			end
			if (sum > SUM_HI)
				sum = SUM_HI;
			if (sum < SUM_LO)
				sum = SUM_LO;
			r.value_write = 1'b1;
			r.new_value = sum[31:0];
		end
		return r;
	endfunction

	function automatic void flag_error(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	always @(posedge clk) begin : monitor
		out_item_t want;
		out_item_t got;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				n_checked++;
				got.status = status_t'(result.status);
				got.action = action_t'(result.action);
				got.value_write = result.value_write;
				got.new_value = result.new_value;
				if (pending.size() == 0) begin
					flag_error($sformatf("unexpected item st=%0d act=%0d wr=%0d val=%h",
						got.status, got.action, got.value_write, got.new_value));
				end else begin
					want = pending.pop_front();
					if (got.status !== want.status || got.action !== want.action ||
							got.value_write !== want.value_write ||
							got.new_value !== want.new_value)
						flag_error($sformatf({"mismatch exp st=%0d act=%0d wr=%0d val=%h",
							" got st=%0d act=%0d wr=%0d val=%h"},
							want.status, want.action, want.value_write, want.new_value,
							got.status, got.action, got.value_write, got.new_value));
				end
			end
			if (knob.valid && knob.ready)
				pending.push_back(decode_knob(knob.layer_active, knob.knob_value,
					knob.current_value));
			if (cfg.valid && cfg.ready)
				apply_reg(reg_idx_t'(cfg.index), cfg.data);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (knob.valid && knob.ready) || (result.valid && result.ready) ||
				(cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("midi_encoder_step_decoder_unit test failed");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	task automatic send_knob(logic la, logic [6:0] kv, logic [31:0] cur);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			knob.valid <= 1'b0;
			repeat (1 + ($urandom_range(3) == 0)) @(posedge clk);
		end
		knob.valid <= 1'b1;
		knob.layer_active <= la;
		knob.knob_value <= kv;
		knob.current_value <= cur;
		do @(posedge clk); while (!knob.ready);
		n_sent++;
	endtask

	task automatic stop_knob();
		knob.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (n_checked < n_sent)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic load_config(logic [3:0] mode, logic [8:0] dly, logic [31:0] su,
			logic [31:0] sd, logic [31:0] sfu, logic [31:0] sfd, logic [31:0] lmin,
			logic [31:0] lmax);
		wait_idle();
		write_reg(REG_MODE, {28'd0, mode});
		write_reg(REG_DELAY, {{23{dly[8]}}, dly});
		write_reg(REG_STEP_UP, su);
		write_reg(REG_STEP_DOWN, sd);
		write_reg(REG_STEP_FUP, sfu);
		write_reg(REG_STEP_FDOWN, sfd);
		write_reg(REG_LIMIT_MIN, lmin);
		write_reg(REG_LIMIT_MAX, lmax);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_q16();
		logic [31:0] r = $urandom;
		case ($urandom_range(6))
			0: return Q_MAX;
			1: return Q_MIN;
			2, 3: return r;
			4, 5: return {{12{r[19]}}, r[19:0]};
			default: return '0;
		endcase
	endfunction

	function automatic logic [6:0] pick_knob();
		case ($urandom_range(3))
			0: return 7'($urandom_range(71, 58));
			1: return $urandom_range(1) ? KNOB_MAX : KNOB_MIN;
			default: return 7'($urandom);
		endcase
	endfunction

	function automatic logic [8:0] pick_delay();
		case ($urandom_range(11))
			0: return 9'h0FF;
			1: return 9'h100;
			2: return 9'($urandom);
			3, 4, 5, 6: return 9'h1FF;
			default: return 9'($urandom_range(3));
		endcase
	endfunction

	task automatic random_config(logic [3:0] mode, logic [8:0] dly);
		load_config(mode, dly, pick_q16(), pick_q16(), pick_q16(), pick_q16(),
			pick_q16(), pick_q16());
	endtask

	task automatic random_items(int count);
		repeat (count)
			send_knob($urandom_range(9) != 0, pick_knob(), pick_q16());
		stop_knob();
	endtask

	// reset defaults: relative command mode, prescaler off
	task automatic test_relative_command();
		logic [6:0] knobs[9] = '{7'd0, 7'd60, 7'd61, 7'd63, 7'd64, 7'd65, 7'd68, 7'd69,
			7'd127};
		foreach (knobs[i])
			send_knob(1'b1, knobs[i], $urandom);
		send_knob(1'b0, 7'd64, $urandom);
		stop_knob();
	endtask

	// no previous knob yet: value range primes, command range treats it as -1
	task automatic test_first_range_message();
		if ($urandom_range(1))
			random_config(M_RANGE | M_VALUE | M_MIN | M_MAX, 9'h1FF);
		else
			random_config(M_RANGE, 9'h1FF);
		send_knob(1'b1, 7'd90, pick_q16());
		send_knob(1'b1, 7'd90, pick_q16());
		send_knob(1'b1, KNOB_MIN, pick_q16());
		send_knob(1'b1, KNOB_MAX, pick_q16());
		stop_knob();
	endtask

	task automatic test_value_clamp();
		// clamps at +/-10.0, zero step still hits the max clamp
		load_config(M_VALUE | M_MIN | M_MAX, 9'h1FF, Q_ONE, -Q_ONE, Q_MAX, Q_MIN,
			32'hFFF6_0000, 32'h000A_0000);
		send_knob(1'b1, 7'd65, 32'h0009_8000);
		send_knob(1'b1, 7'd62, 32'hFFF6_8000);
		send_knob(1'b1, 7'd64, 32'h0014_0000);
		stop_knob();
		// no clamps: saturation at both ends
		load_config(M_VALUE, 9'h1FF, Q_ONE, -Q_ONE, Q_MAX, Q_MIN, '0, '0);
		send_knob(1'b1, KNOB_MAX, Q_MAX);
		send_knob(1'b1, KNOB_MIN, Q_MIN);
		stop_knob();
		// inverted limits applied as given
		load_config(M_VALUE | M_MIN | M_MAX, 9'h1FF, Q_ONE, -Q_ONE, Q_ONE, -Q_ONE,
			32'h0005_0000, 32'hFFFB_0000);
		send_knob(1'b1, 7'd65, '0);
		send_knob(1'b1, 7'd62, '0);
		stop_knob();
	endtask

	task automatic test_prescaler();
		load_config('0, 9'd2, '0, '0, '0, '0, '0, '0);
		send_knob(1'b1, 7'd70, '0);
		send_knob(1'b1, 7'd50, '0);
		send_knob(1'b0, 7'd62, '0);
		send_knob(1'b1, 7'd66, '0);
		send_knob(1'b1, 7'd10, '0);
		stop_knob();
	endtask

	task automatic test_receiver_holdoff();
		random_config(M_VALUE | 4'($urandom_range(15)), 9'h1FF);
		hold_req = 1'b1;
		random_items(80);
	endtask

	task automatic test_steady_stream();
		random_config(4'($urandom_range(15)), 9'($urandom_range(1)));
		idle_pct = 0;
		random_items(150);
		wait_idle();
		idle_pct = 18;
	endtask

	task automatic test_random_phases();
		logic [3:0] mode;
		logic [8:0] dly;
		for (int p = 0; p < RAND_PHASES; p++) begin
			mode = 4'($urandom_range(15));
			dly = pick_delay();
			case (p)
				0: mode = '0;
				1: mode = M_RANGE | M_VALUE | M_MIN | M_MAX;
				2: dly = 9'h0FF;
				3: dly = 9'h100;
				default: ;
			endcase
			random_config(mode, dly);
			random_items(PHASE_ITEMS);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		knob.valid <= 1'b0;
		knob.layer_active <= 1'b0;
		knob.knob_value <= '0;
		knob.current_value <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_MODE;
		cfg.data <= '0;
		dec_cfg = '0;
		dec_cfg.delay_count = '1;
		last_knob = '0;
		last_known = 1'b0;
		skip_cnt = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_relative_command();
		test_first_range_message();
		test_value_clamp();
		test_prescaler();
		test_receiver_holdoff();
		test_steady_stream();
		test_random_phases();
		wait_idle();
		if (pending.size() != 0)
			flag_error($sformatf("%0d expected items never arrived", pending.size()));
		if (mismatches == 0)
			$display("midi_encoder_step_decoder_unit test passed");
		else
			$display("midi_encoder_step_decoder_unit test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mesd_pkg.sv
rtl/mesd_if.sv
rtl/mesd_cfg_regs.sv
rtl/mesd_step.sv
rtl/midi_encoder_step_decoder_unit.sv
tb/tb.sv
